>>> rtl/b64d_pkg.sv
package b64d_pkg;

    localparam int MaxResults = 3;
    localparam int QueueDepth = 8;
    localparam int QueueAw    = 3;
    localparam int QueueCntW  = 4;

    localparam logic [7:0] PadChar = 8'h3D;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LENGTH = 2'd1,
        ST_BAD_CHAR   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_symbol;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        t_status    status;
    } t_out_item;

    // results of one character, slot 0 goes out first
    typedef struct packed {
        logic [1:0]                     count;
        t_out_item [MaxResults-1:0]     item;
    } t_push;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet r;
        r.ok    = 1'b1;
        r.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.value = 6'd62;
        end else if (c == 8'h2F) begin
            r.value = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> rtl/b64d_decode.sv
module b64d_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  b64d_pkg::t_in_item i_in_item,
    input  logic              i_room,
    output b64d_pkg::t_push   o_push
);

    logic                 r_in_valid;
    b64d_pkg::t_in_item   r_in_item;

    logic [1:0]  r_phase, n_phase;
    logic [17:0] r_held, n_held;
    logic [1:0]  r_pad, n_pad;
    logic [1:0]  r_len, n_len;
    logic        r_err, n_err;

    logic               process;
    b64d_pkg::t_sextet  sx;
    b64d_pkg::t_status  status;
    logic [1:0]         nb;
    logic [7:0]         b0, b1, b2;

    assign process    = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || i_room;
    assign sx         = b64d_pkg::sextet_of(r_in_item.symbol);

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_pad   = r_pad;
        n_len   = r_len + 2'd1;
        n_err   = r_err;
        nb      = 2'd0;
        b0      = 8'd0;
        b1      = 8'd0;
        b2      = 8'd0;
        status  = b64d_pkg::ST_OK;
        o_push  = '0;

        if (!r_err) begin
            if (r_in_item.symbol == b64d_pkg::PadChar) begin
                if (r_pad >= 2'd2) begin
                    n_err = 1'b1;
                end else begin
                    n_pad = r_pad + 2'd1;
                end
            end else if (!sx.ok || r_pad != 2'd0) begin
                n_err = 1'b1;
            end else if (r_phase == 2'd3) begin
                b0      = r_held[17:10];
                b1      = r_held[9:2];
                b2      = {r_held[1:0], sx.value};
                nb      = 2'd3;
                n_phase = 2'd0;
                n_held  = 18'd0;
            end else begin
                n_held  = {r_held[11:0], sx.value};
                n_phase = r_phase + 2'd1;
            end
        end

        if (r_in_item.final_symbol) begin
            if (n_len != 2'd0) begin
                status = b64d_pkg::ST_BAD_LENGTH;
            end else if (n_err) begin
                status = b64d_pkg::ST_BAD_CHAR;
            end
            if (status == b64d_pkg::ST_OK && nb == 2'd0) begin
                // short trailing group, pad bits dropped
                if (n_phase == 2'd3) begin
                    b0 = n_held[17:10];
                    b1 = n_held[9:2];
                    nb = 2'd2;
                end else if (n_phase == 2'd2) begin
                    b0 = n_held[11:4];
                    nb = 2'd1;
                end
            end
            if (status != b64d_pkg::ST_OK || nb == 2'd0) begin
                o_push.count                  = 2'd1;
                o_push.item[0].end_of_message = 1'b1;
                o_push.item[0].status         = status;
            end else begin
                o_push.count = nb;
                o_push.item[0].data_byte  = b0;
                o_push.item[0].byte_valid = 1'b1;
                o_push.item[1].data_byte  = b1;
                o_push.item[1].byte_valid = (nb >= 2'd2);
                o_push.item[2].data_byte  = b2;
                o_push.item[2].byte_valid = (nb == 2'd3);
                o_push.item[nb - 2'd1].end_of_message = 1'b1;
            end
            n_phase = 2'd0;
            n_held  = 18'd0;
            n_pad   = 2'd0;
            n_len   = 2'd0;
            n_err   = 1'b0;
        end else begin
            o_push.count = nb;
            o_push.item[0].data_byte  = b0;
            o_push.item[0].byte_valid = (nb != 2'd0);
            o_push.item[1].data_byte  = b1;
            o_push.item[1].byte_valid = (nb != 2'd0);
            o_push.item[2].data_byte  = b2;
            o_push.item[2].byte_valid = (nb != 2'd0);
        end

        if (!process) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= 2'd0;
            r_held     <= 18'd0;
            r_pad      <= 2'd0;
            r_len      <= 2'd0;
            r_err      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (process) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_pad   <= n_pad;
                r_len   <= n_len;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

endmodule

>>> rtl/b64d_queue.sv
module b64d_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64d_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64d_pkg::t_out_item o_out_item
);

    localparam int RoomLimit = b64d_pkg::QueueDepth - b64d_pkg::MaxResults;

    b64d_pkg::t_out_item r_mem [b64d_pkg::QueueDepth];

    logic [b64d_pkg::QueueAw-1:0]   r_wr, r_rd;
    logic [b64d_pkg::QueueCntW-1:0] r_cnt, n_cnt;
    logic                           pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_mem[r_rd];
    assign pop         = o_out_valid && i_out_ready;
    assign o_room      = (r_cnt <= b64d_pkg::QueueCntW'(RoomLimit));

    always_comb begin
        n_cnt = r_cnt + b64d_pkg::QueueCntW'(i_push.count)
                      - b64d_pkg::QueueCntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + b64d_pkg::QueueAw'(i_push.count);
            r_rd  <= r_rd + b64d_pkg::QueueAw'(pop);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < b64d_pkg::MaxResults; k++) begin
            if (2'(k) < i_push.count) begin
                r_mem[r_wr + b64d_pkg::QueueAw'(k)] <= i_push.item[k];
            end
        end
    end

endmodule

>>> rtl/base64_decoder_checked_core.sv
// streaming base64 decoder with alphabet, padding and length checks
//
// input channel: one character per transfer (i_in_valid / o_in_ready),
//   final_symbol marks the last character of a message
// output channel: one result per transfer (o_out_valid / i_out_ready);
//   a character yields zero to three results: three bytes when a group of
//   four completes, and the closing result carries end_of_message and status
// on a bad status the closing result has byte_valid low and the consumer
//   drops the bytes it already took for that message
// path: a character is accepted into the input register, decoded from it
//   and written to the result queue when the queue has room; its results
//   are then valid at the queue output
// throughput: one character per cycle; the 8-entry result queue takes a
//   decoded character only when it has room for three results
// stall: when the receiver holds i_out_ready low the queue fills, the input
//   register then holds its character and o_in_ready drops
// reset: synchronous, active low; clears the queue, the input register and
//   all decoder state so the next character starts a new message
module base64_decoder_checked_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  b64d_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64d_pkg::t_out_item o_out_item
);

    // decoded results of one character headed for the queue
    b64d_pkg::t_push push;
    // queue can take a full group of three
    logic            room;

    b64d_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_room     (room),
        .o_push     (push)
    );

    b64d_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/b64d_checker.sv
module b64d_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input b64d_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input b64d_pkg::t_out_item o_out_item
);

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // waiting character holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("waiting character changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // empty slot carries a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_valid |-> o_out_item.data_byte == 8'd0)
        else $error("nonzero byte without byte_valid");

    // status only on the closing result, and an error close has no byte
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != b64d_pkg::ST_OK |->
            o_out_item.end_of_message && !o_out_item.byte_valid &&
            (o_out_item.status == b64d_pkg::ST_BAD_LENGTH ||
             o_out_item.status == b64d_pkg::ST_BAD_CHAR))
        else $error("bad status placement");

endmodule

bind base64_decoder_checked_core b64d_checker u_b64d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
